// ===== design/assert_macros.svh =====
// assertion macros shared by the sampler rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, masked while reset is applied
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// implication shorthand on the same clock edge
`define ASSERT_IMPLY(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

`endif

// ===== design/bts_pkg.sv =====
// types and constants shared by the texture sampler modules
package bts_pkg;

	localparam int CFG_DATA_W  = 9;
	localparam int CFG_INDEX_W = 3;
	localparam int CHAN_W      = 16;
	localparam int TEXEL_W     = 3 * CHAN_W;
	localparam int STORE_AW    = 16;
	localparam int STORE_DEPTH = 1 << STORE_AW;
	localparam int COORD_W     = 32;

	localparam logic OP_WRITE  = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	localparam logic WRAP_REPEAT = 1'b0;
	localparam logic WRAP_CLAMP  = 1'b1;

	localparam logic FILTER_NEAREST  = 1'b0;
	localparam logic FILTER_BILINEAR = 1'b1;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_TEX_WIDTH   = 3'd0,
		CFG_TEX_HEIGHT  = 3'd1,
		CFG_WRAP_MODE_U = 3'd2,
		CFG_WRAP_MODE_V = 3'd3,
		CFG_FILTER_MODE = 3'd4
	} cfg_index_t;

	typedef struct packed {
		logic                      opcode;
		logic [STORE_AW-1:0]       texel_address;
		logic [CHAN_W-1:0]         red_in;
		logic [CHAN_W-1:0]         green_in;
		logic [CHAN_W-1:0]         blue_in;
		logic signed [COORD_W-1:0] u_coord;
		logic signed [COORD_W-1:0] v_coord;
	} in_item_t;

	typedef struct packed {
		logic [CHAN_W-1:0] red_out;
		logic [CHAN_W-1:0] green_out;
		logic [CHAN_W-1:0] blue_out;
	} out_item_t;

	typedef struct packed {
		logic [CFG_DATA_W-1:0] tex_width;
		logic [CFG_DATA_W-1:0] tex_height;
		logic                  wrap_mode_u;
		logic                  wrap_mode_v;
		logic                  filter_mode;
	} cfg_t;

endpackage

// ===== design/bts_fifo.sv =====
// small register queue with occupancy count
module bts_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = 4
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  logic [W-1:0]                 wdata,
	input  logic                         pop,
	output logic [W-1:0]                 rdata,
	output logic                         full,
	output logic                         empty,
	output logic [$clog2(DEPTH+1)-1:0]   count
);
	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH+1);

	logic [W-1:0]    mem_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push;
	logic            do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign count   = count_q;
	assign rdata   = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH-1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH-1)) ? '0 : rd_ptr_q + AW'(1);
			end
			case ({do_push, do_pop})
				2'b10: count_q <= count_q + CW'(1);
				2'b01: count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

// ===== design/bts_front.sv =====
// front end: packs requests and wraps the coordinates
module bts_front #(
	parameter int COORD_FRAC_BITS = 16
) (
	input  bts_pkg::in_item_t                  request,
	input  bts_pkg::cfg_t                      cfg,
	output logic [2*(COORD_FRAC_BITS+1)+bts_pkg::TEXEL_W+bts_pkg::STORE_AW:0] mid_data
);
	localparam int FB = COORD_FRAC_BITS;
	localparam int WW = FB + 1;

	logic [WW-1:0] wu;
	logic [WW-1:0] wv;

	function automatic logic [WW-1:0] wrap(input logic [bts_pkg::COORD_W-1:0] raw,
		input logic mode);
		logic [WW-1:0] res;
		if (mode == bts_pkg::WRAP_REPEAT) begin
			res = {1'b0, raw[FB-1:0]};
		end else if (raw[bts_pkg::COORD_W-1]) begin
			res = '0;
		end else if (raw > (bts_pkg::COORD_W'(1) << FB)) begin
			res = WW'(1) << FB;
		end else begin
			res = raw[WW-1:0];
		end
		return res;
	endfunction

	assign wu = wrap(request.u_coord, cfg.wrap_mode_u);
	assign wv = wrap(request.v_coord, cfg.wrap_mode_v);

	assign mid_data = {request.opcode, request.texel_address, request.red_in,
		request.green_in, request.blue_in, wu, wv};

endmodule

// ===== design/bts_back.sv =====
// back end: index math, banked texel store and the two lerp stages
module bts_back #(
	parameter int MAX_WIDTH       = 256,
	parameter int MAX_HEIGHT      = 256,
	parameter int COORD_FRAC_BITS = 16,
	parameter int OUT_DEPTH       = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  bts_pkg::cfg_t                cfg,
	input  logic [2*(COORD_FRAC_BITS+1)+bts_pkg::TEXEL_W+bts_pkg::STORE_AW:0] mid_data,
	input  logic                         mid_empty,
	output logic                         mid_pop,
	input  logic [$clog2(OUT_DEPTH+1)-1:0] out_count,
	output logic                         out_push,
	output bts_pkg::out_item_t           out_data
);
	localparam int FB  = COORD_FRAC_BITS;
	localparam int CWD = FB + 1;
	localparam int WW  = $clog2(MAX_WIDTH + 1);
	localparam int HW  = $clog2(MAX_HEIGHT + 1);
	localparam int XW  = $clog2(MAX_WIDTH);
	localparam int YW  = $clog2(MAX_HEIGHT);
	localparam int SXW = CWD + WW;
	localparam int SYW = CWD + HW;
	localparam int IW  = (YW + WW + 1 > bts_pkg::STORE_AW) ? YW + WW + 1 : bts_pkg::STORE_AW;
	localparam int LW  = bts_pkg::CHAN_W + FB + 2;
	localparam int CW  = $clog2(OUT_DEPTH + 1);
	localparam int SW  = (CW > 3) ? CW + 1 : 4;
	localparam int AW  = bts_pkg::STORE_AW;
	localparam int TW  = bts_pkg::TEXEL_W;
	localparam int CH  = bts_pkg::CHAN_W;
	localparam logic [LW-1:0] ONE_L  = LW'(1) << FB;
	localparam logic [LW-1:0] HALF_L = LW'(1) << (FB - 1);

	// effective sizes, from static configuration
	logic [WW-1:0] w_eff;
	logic [HW-1:0] h_eff;
	logic          tex_empty;

	assign w_eff = (32'(cfg.tex_width) > 32'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(cfg.tex_width);
	assign h_eff = (32'(cfg.tex_height) > 32'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) :
		HW'(cfg.tex_height);
	assign tex_empty = (w_eff == '0) || (h_eff == '0);

	// issue only with a guaranteed slot in the result queue
	logic [2:0] inflight;
	logic       v_s1, v_s2, v_s3, v_s4, v_s5;

	assign inflight = 3'(v_s1) + 3'(v_s2) + 3'(v_s3) + 3'(v_s4) + 3'(v_s5);
	assign mid_pop  = !mid_empty && ((SW'(out_count) + SW'(inflight)) < SW'(OUT_DEPTH));

	// stage 1: captured queue entry
	logic            op_s1;
	logic [AW-1:0]   addr_s1;
	logic [TW-1:0]   texel_s1;
	logic [CWD-1:0]  wu_s1, wv_s1;

	// stage 2: scaled coordinates
	logic            op_s2;
	logic [AW-1:0]   addr_s2;
	logic [TW-1:0]   texel_s2;
	logic [XW-1:0]   x0_s2;
	logic [YW-1:0]   y0_s2;
	logic [FB-1:0]   tx_s2, ty_s2;
	logic [SXW-1:0]  sx;
	logic [SYW-1:0]  sy;

	// stage 3: store indexes
	logic            op_s3;
	logic [TW-1:0]   texel_s3;
	logic [FB-1:0]   tx_s3, ty_s3;
	logic [AW-1:0]   idx_s3 [4];
	logic [WW-1:0]   x0p;
	logic [HW-1:0]   y0p;
	logic [XW-1:0]   x1;
	logic [YW-1:0]   y1;

	// stage 4: texel reads
	logic            samp_s4;
	logic [FB-1:0]   tx_s4, ty_s4;
	logic [TW-1:0]   rd_s4 [4];

	// stage 5: horizontal lerps
	logic            samp_s5;
	logic [FB-1:0]   ty_s5;
	logic [TW-1:0]   top_s5, bot_s5, near_s5;
	logic [TW-1:0]   top_c, bot_c, blend_c;

	function automatic logic [CH-1:0] lerp(input logic [CH-1:0] a, input logic [CH-1:0] b,
		input logic [FB-1:0] t);
		logic [LW-1:0] acc;
		acc = LW'(a) * (ONE_L - LW'(t)) + LW'(b) * LW'(t) + HALF_L;
		return acc[FB +: CH];
	endfunction

	assign sx = SXW'(wu_s1) * SXW'(w_eff - WW'(1));
	assign sy = SYW'(wv_s1) * SYW'(h_eff - HW'(1));

	assign x0p = WW'(x0_s2) + WW'(1);
	assign y0p = HW'(y0_s2) + HW'(1);
	assign x1  = (x0p == w_eff) ? '0 : XW'(x0p);
	assign y1  = (y0p == h_eff) ? '0 : YW'(y0p);

	function automatic logic [AW-1:0] index(input logic [YW-1:0] row, input logic [XW-1:0] col,
		input logic [WW-1:0] wd);
		logic [IW-1:0] full_idx;
		full_idx = IW'(row) * IW'(wd) + IW'(col);
		return full_idx[AW-1:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= mid_pop;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		{op_s1, addr_s1, texel_s1, wu_s1, wv_s1} <= mid_data;

		op_s2    <= op_s1;
		addr_s2  <= addr_s1;
		texel_s2 <= texel_s1;
		x0_s2    <= sx[FB +: XW];
		y0_s2    <= sy[FB +: YW];
		tx_s2    <= sx[FB-1:0];
		ty_s2    <= sy[FB-1:0];

		op_s3     <= op_s2;
		texel_s3  <= texel_s2;
		tx_s3     <= tx_s2;
		ty_s3     <= ty_s2;
		// a write carries its address in the first index slot
		idx_s3[0] <= (op_s2 == bts_pkg::OP_WRITE) ? addr_s2 : index(y0_s2, x0_s2, w_eff);
		idx_s3[1] <= index(y0_s2, x1, w_eff);
		idx_s3[2] <= index(y1, x0_s2, w_eff);
		idx_s3[3] <= index(y1, x1, w_eff);

		samp_s4 <= v_s3 && (op_s3 == bts_pkg::OP_SAMPLE);
		tx_s4   <= tx_s3;
		ty_s4   <= ty_s3;

		samp_s5 <= samp_s4;
		ty_s5   <= ty_s4;
		top_s5  <= top_c;
		bot_s5  <= bot_c;
		near_s5 <= rd_s4[0];
	end

	// four copies of the store, one read port each, all written together
	for (genvar k = 0; k < 4; k++) begin : g_bank
		logic [TW-1:0] mem [bts_pkg::STORE_DEPTH];

		always_ff @(posedge clk) begin
			if (v_s3 && (op_s3 == bts_pkg::OP_WRITE)) begin
				mem[idx_s3[0]] <= texel_s3;
			end
			rd_s4[k] <= mem[idx_s3[k]];
		end
	end

	for (genvar c = 0; c < 3; c++) begin : g_chan
		assign top_c[c*CH +: CH]   = lerp(rd_s4[0][c*CH +: CH], rd_s4[1][c*CH +: CH], tx_s4);
		assign bot_c[c*CH +: CH]   = lerp(rd_s4[2][c*CH +: CH], rd_s4[3][c*CH +: CH], tx_s4);
		assign blend_c[c*CH +: CH] = lerp(top_s5[c*CH +: CH], bot_s5[c*CH +: CH], ty_s5);
	end

	assign out_push = v_s5 && samp_s5;

	always_comb begin
		if (tex_empty) begin
			out_data = '0;
		end else if (cfg.filter_mode == bts_pkg::FILTER_NEAREST) begin
			out_data = bts_pkg::out_item_t'(near_s5);
		end else begin
			out_data = bts_pkg::out_item_t'(blend_c);
		end
	end

endmodule

// ===== design/bilinear_texture_sampler.sv =====
// Texture store and bilinear sampler. One request (texel write or sample) is taken per
// cycle while the request queue is not full, and one result per cycle can be drained;
// a sample gives one result, writes give no result. The texel store is kept in four copies:
// each copy has one read port so the four bilinear taps are fetched in the same cycle, and
// every write goes to all four copies. Configuration is written through cfg_we/cfg_index.
module bilinear_texture_sampler #(
	parameter int MAX_WIDTH       = 256,
	parameter int MAX_HEIGHT      = 256,
	parameter int COORD_FRAC_BITS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [bts_pkg::CFG_INDEX_W-1:0]       cfg_index,
	input  logic [bts_pkg::CFG_DATA_W-1:0]        cfg_data,
	input  logic                                  push,
	output logic                                  full,
	input  bts_pkg::in_item_t                     request,
	input  logic                                  pop,
	output logic                                  empty,
	output bts_pkg::out_item_t                    result
);
`include "assert_macros.svh"

	localparam int MID_DEPTH = 4;
	localparam int OUT_DEPTH = 8;
	localparam int MID_W     = 2 * (COORD_FRAC_BITS + 1) + bts_pkg::TEXEL_W + bts_pkg::STORE_AW + 1;
	localparam int OUT_W     = bts_pkg::TEXEL_W;

	bts_pkg::cfg_t cfg_q;

	logic [MID_W-1:0] mid_wdata, mid_rdata;
	logic             mid_full, mid_empty, mid_pop;
	logic [$clog2(MID_DEPTH+1)-1:0] mid_count;

	logic [$clog2(OUT_DEPTH+1)-1:0] out_count;
	logic             out_push, out_full;
	bts_pkg::out_item_t out_data;
	logic [OUT_W-1:0] out_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tex_width   <= '0;
			cfg_q.tex_height  <= '0;
			cfg_q.wrap_mode_u <= bts_pkg::WRAP_REPEAT;
			cfg_q.wrap_mode_v <= bts_pkg::WRAP_REPEAT;
			cfg_q.filter_mode <= bts_pkg::FILTER_BILINEAR;
		end else if (cfg_we) begin
			case (bts_pkg::cfg_index_t'(cfg_index))
				bts_pkg::CFG_TEX_WIDTH:   cfg_q.tex_width   <= cfg_data;
				bts_pkg::CFG_TEX_HEIGHT:  cfg_q.tex_height  <= cfg_data;
				bts_pkg::CFG_WRAP_MODE_U: cfg_q.wrap_mode_u <= cfg_data[0];
				bts_pkg::CFG_WRAP_MODE_V: cfg_q.wrap_mode_v <= cfg_data[0];
				bts_pkg::CFG_FILTER_MODE: cfg_q.filter_mode <= cfg_data[0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	bts_front #(
		.COORD_FRAC_BITS(COORD_FRAC_BITS)
	) u_front (
		.request (request),
		.cfg     (cfg_q),
		.mid_data(mid_wdata)
	);

	bts_fifo #(
		.W    (MID_W),
		.DEPTH(MID_DEPTH)
	) u_mid_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata (mid_wdata),
		.pop   (mid_pop),
		.rdata (mid_rdata),
		.full  (mid_full),
		.empty (mid_empty),
		.count (mid_count)
	);

	assign full = mid_full;

	bts_back #(
		.MAX_WIDTH      (MAX_WIDTH),
		.MAX_HEIGHT     (MAX_HEIGHT),
		.COORD_FRAC_BITS(COORD_FRAC_BITS),
		.OUT_DEPTH      (OUT_DEPTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.mid_data (mid_rdata),
		.mid_empty(mid_empty),
		.mid_pop  (mid_pop),
		.out_count(out_count),
		.out_push (out_push),
		.out_data (out_data)
	);

	bts_fifo #(
		.W    (OUT_W),
		.DEPTH(OUT_DEPTH)
	) u_out_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (out_push),
		.wdata (out_data),
		.pop   (pop),
		.rdata (out_rdata),
		.full  (out_full),
		.empty (empty),
		.count (out_count)
	);

	assign result = bts_pkg::out_item_t'(out_rdata);

	// credit scheme must keep the result queue from overflowing
	`ASSERT_IMPLY(a_out_no_overflow, clk, arst_n, out_push, !out_full, "result queue overflow")
	`ASSERT_IMPLY(a_mid_pop_valid, clk, arst_n, mid_pop, !mid_empty, "pop from empty mid queue")
	`ASSERT_CLK(a_result_source, clk, arst_n, $fell(empty) |-> $past(out_push),
		"result appeared without a back-end transfer")
	`ASSERT_IMPLY(a_mid_count, clk, arst_n, mid_full, mid_count == 3'(MID_DEPTH),
		"mid queue full flag disagrees with count")

endmodule
